FILE: rtl/ffsp_pkg.sv
// Package for the fixed-length frame sync parser.
// Frame constants, parser state and per-request event types.
// No dependencies.
package ffsp_pkg;

    localparam int unsigned WIN_LEN = 5;
    localparam int unsigned HOLD_LEN = WIN_LEN - 1;

    localparam logic [7:0] HDR_BYTE     = 8'h5A;
    localparam logic [7:0] KIND_RATE    = 8'hAA;
    localparam logic [7:0] KIND_HEADING = 8'hBB;

    localparam logic [2:0] FILL_EMPTY = 3'd0;
    localparam logic [2:0] FILL_FULL  = 3'(HOLD_LEN);

    localparam logic ACC_KIND_RATE    = 1'b0;
    localparam logic ACC_KIND_HEADING = 1'b1;

    // Only the four oldest bytes are held; the fifth is the incoming byte.
    typedef struct packed {
        logic [HOLD_LEN-1:0][7:0] window;
        logic [2:0]               fill;
        logic signed [15:0]       last_rate;
        logic signed [15:0]       last_heading;
        logic                     seen_valid;
        logic [31:0]              frame_cnt;
        logic [31:0]              err_cnt;
    } ffsp_state_t;

    typedef struct packed {
        logic accepted;
        logic failed;
        logic kind;
    } ffsp_event_t;

endpackage

FILE: rtl/ffsp_check.sv
// Frame check logic: window update, header/type/sum check, counters.
// Purely combinational; depends on ffsp_pkg.
module ffsp_check (
    input  ffsp_pkg::ffsp_state_t state_cur,
    input  logic [7:0]            rx_byte,
    output ffsp_pkg::ffsp_state_t state_next,
    output ffsp_pkg::ffsp_event_t evt
);

    logic               full;
    logic               hdr_ok;
    logic               type_ok;
    logic [7:0]         sum;
    logic signed [15:0] value;

    assign full    = (state_cur.fill == ffsp_pkg::FILL_FULL);
    assign hdr_ok  = (state_cur.window[0] == ffsp_pkg::HDR_BYTE);
    assign type_ok = (state_cur.window[1] == ffsp_pkg::KIND_RATE) ||
                     (state_cur.window[1] == ffsp_pkg::KIND_HEADING);
    assign sum     = state_cur.window[0] + state_cur.window[1] +
                     state_cur.window[2] + state_cur.window[3];
    assign value   = {state_cur.window[3], state_cur.window[2]};

    always_comb begin
        state_next = state_cur;
        evt        = '0;
        if (!full) begin
            state_next.window[state_cur.fill[1:0]] = rx_byte;
            state_next.fill = state_cur.fill + 3'd1;
        end else if (hdr_ok && type_ok && (sum == rx_byte)) begin
            if (state_cur.window[1] == ffsp_pkg::KIND_RATE) begin
                state_next.last_rate = value;
                evt.kind = ffsp_pkg::ACC_KIND_RATE;
            end else begin
                state_next.last_heading = value;
                evt.kind = ffsp_pkg::ACC_KIND_HEADING;
            end
            state_next.frame_cnt  = state_cur.frame_cnt + 32'd1;
            state_next.seen_valid = 1'b1;
            state_next.fill       = ffsp_pkg::FILL_EMPTY;
            evt.accepted          = 1'b1;
        end else begin
            // drop oldest byte
            state_next.window = {rx_byte, state_cur.window[3], state_cur.window[2],
                                 state_cur.window[1]};
            state_next.fill   = ffsp_pkg::FILL_FULL;
            if (hdr_ok && type_ok) begin
                state_next.err_cnt = state_cur.err_cnt + 32'd1;
                evt.failed         = 1'b1;
            end
        end
    end

endmodule

FILE: rtl/fixed_frame_sync_parser_core.sv
// A request passes the input register, then the result register, to the result.
// Throughput: one byte per cycle while m_ready is high; the check of a full
// five-byte window is a single 8-bit add/compare between those two registers.
// Reset: aresetn synchronous active low; clears window, fill, values, valid flag,
// both counters and both handshake stages.
// Top level of the frame sync parser; depends on ffsp_pkg and ffsp_check.
module fixed_frame_sync_parser_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_frame_accepted,
    output logic               m_sum_failed,
    output logic               m_accepted_kind,
    output logic signed [15:0] m_rate_raw,
    output logic signed [15:0] m_heading_raw,
    output logic               m_data_valid,
    output logic [31:0]        m_good_frames,
    output logic [31:0]        m_sum_errors
);

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    ffsp_pkg::ffsp_state_t state_reg;
    ffsp_pkg::ffsp_state_t state_next;
    ffsp_pkg::ffsp_event_t evt;
    ffsp_pkg::ffsp_event_t evt_reg;
    ffsp_pkg::ffsp_state_t out_reg;
    logic                  m_valid_reg;
    logic                  advance;

    ffsp_check u_check (
        .state_cur  (state_reg),
        .rx_byte    (in_byte_reg),
        .state_next (state_next),
        .evt        (evt)
    );

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            state_reg    <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (advance) begin
            out_reg <= state_next;
            evt_reg <= evt;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_frame_accepted = evt_reg.accepted;
    assign m_sum_failed     = evt_reg.failed;
    assign m_accepted_kind  = evt_reg.kind;
    assign m_rate_raw       = out_reg.last_rate;
    assign m_heading_raw    = out_reg.last_heading;
    assign m_data_valid     = out_reg.seen_valid;
    assign m_good_frames    = out_reg.frame_cnt;
    assign m_sum_errors     = out_reg.err_cnt;

endmodule

FILE: rtl/ffsp_checker.sv
// Port-level checker for fixed_frame_sync_parser_core, with its bind.
// No dependencies beyond the top level's ports.
module ffsp_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_frame_accepted,
    input logic               m_sum_failed,
    input logic               m_accepted_kind,
    input logic               m_data_valid,
    input logic [31:0]        m_good_frames
);

    a_event_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_frame_accepted && m_sum_failed))
        else $error("frame accepted and sum failed together");

    a_kind_needs_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_accepted_kind) |-> m_frame_accepted)
        else $error("heading kind without accepted frame");

    a_accept_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_accepted) |-> m_data_valid)
        else $error("accepted frame without data valid");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_good_frames)))
        else $error("result request changed while stalled");

endmodule

bind fixed_frame_sync_parser_core ffsp_checker u_ffsp_checker (.*);
